>>> design/mrps_pkg.sv
// ----------------------------------------------------------------------------
// mrps_pkg
// Shared types and constants for the memory range page size splitter.
// ----------------------------------------------------------------------------
package mrps_pkg;

    localparam int ADDR_W              = 52;
    localparam int PHYS_ADDR_BITS_DEF  = 52;
    localparam int FRAME_SHIFT         = 12;
    localparam int LG_FRAMES_2M        = 9;
    localparam int LG_FRAMES_1G        = 18;

    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;
    localparam int LPE_W               = 2;

    localparam logic       CFG_IDX_LPE = 1'b0;
    localparam logic [1:0] TAG_4K      = 2'b00;
    localparam logic [1:0] TAG_2M      = 2'b01;
    localparam logic [1:0] TAG_2M_1G   = 2'b11;

    typedef struct packed {
        logic [ADDR_W-1:0] range_start_addr;
        logic [ADDR_W-1:0] range_end_addr;
    } t_range_in;

    typedef struct packed {
        logic [ADDR_W-1:0] piece_start_addr;
        logic [ADDR_W-1:0] piece_end_addr;
        logic [1:0]        piece_page_size;
        logic              piece_last;
    } t_piece_out;

    typedef enum logic [2:0] {
        SEG_HEAD_4K,
        SEG_RUN_2M,
        SEG_MID_1G,
        SEG_TAIL_2M,
        SEG_TAIL_4K
    } t_seg_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_RUN2M,
        ST_MID1G,
        ST_TAIL2M,
        ST_TAIL4K,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic emit;
        logic last;
        logic pend_load;
        logic pend_extend;
        logic pend_clear;
        logic pos_load;
    } t_seq_ctl;

endpackage

>>> design/mrps_cfg.sv
// ----------------------------------------------------------------------------
// mrps_cfg
// APB register block holding the large page enable mask.
// ----------------------------------------------------------------------------
module mrps_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrps_pkg::PADDR_W-1:0] paddr,
    input  logic [mrps_pkg::PDATA_W-1:0] pwdata,
    output logic [mrps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [mrps_pkg::LPE_W-1:0]   o_lpe
);
    import mrps_pkg::*;

    logic [LPE_W-1:0] r_lpe;
    logic             wr_en;
    logic             sel_lpe;

    assign sel_lpe = (paddr[PADDR_W-1] == CFG_IDX_LPE);
    assign wr_en   = psel && penable && pwrite && sel_lpe;
    assign pready  = 1'b1;
    assign o_lpe   = r_lpe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpe <= '0;
        end else if (wr_en) begin
            r_lpe <= pwdata[LPE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_lpe) begin
            prdata[LPE_W-1:0] = r_lpe;
        end
    end

endmodule

>>> design/mrps_seg_unit.sv
// ----------------------------------------------------------------------------
// mrps_seg_unit
// Shared align and clamp unit: bounds and tag of one candidate piece.
// ----------------------------------------------------------------------------
module mrps_seg_unit #(
    parameter int FRAME_W = mrps_pkg::PHYS_ADDR_BITS_DEF - mrps_pkg::FRAME_SHIFT
) (
    input  mrps_pkg::t_seg_sel         i_sel,
    input  logic [FRAME_W-1:0]         i_pos,
    input  logic [FRAME_W-1:0]         i_limit,
    input  logic [mrps_pkg::LPE_W-1:0] i_lpe,
    output logic [FRAME_W-1:0]         o_start,
    output logic [FRAME_W-1:0]         o_end,
    output logic [1:0]                 o_tag,
    output logic                       o_nonempty
);
    import mrps_pkg::*;

    localparam int W = FRAME_W + 1;
    localparam logic [W-1:0] M2 = {{(W-LG_FRAMES_2M){1'b0}}, {LG_FRAMES_2M{1'b1}}};
    localparam logic [W-1:0] M1 = {{(W-LG_FRAMES_1G){1'b0}}, {LG_FRAMES_1G{1'b1}}};

    logic [W-1:0] pos_x;
    logic [W-1:0] lim_x;
    logic [W-1:0] up2m;
    logic [W-1:0] up1g;
    logic [W-1:0] dn2m;
    logic [W-1:0] dn1g;
    logic [W-1:0] s;
    logic [W-1:0] e;

    assign pos_x = {1'b0, i_pos};
    assign lim_x = {1'b0, i_limit};
    assign up2m  = (pos_x + M2) & ~M2;
    assign up1g  = (pos_x + M1) & ~M1;
    assign dn2m  = lim_x & ~M2;
    assign dn1g  = lim_x & ~M1;

    always_comb begin
        unique case (i_sel)
            SEG_HEAD_4K: begin
                s     = pos_x;
                e     = (up2m < lim_x) ? up2m : lim_x;
                o_tag = TAG_4K;
            end
            SEG_RUN_2M: begin
                s     = up2m;
                e     = (up1g < dn2m) ? up1g : dn2m;
                o_tag = i_lpe & TAG_2M;
            end
            SEG_MID_1G: begin
                s     = up1g;
                e     = dn1g;
                o_tag = i_lpe & TAG_2M_1G;
            end
            SEG_TAIL_2M: begin
                s     = up2m;
                e     = dn2m;
                o_tag = i_lpe & TAG_2M;
            end
            SEG_TAIL_4K: begin
                s     = pos_x;
                e     = lim_x;
                o_tag = TAG_4K;
            end
            default: begin
                s     = pos_x;
                e     = pos_x;
                o_tag = TAG_4K;
            end
        endcase
    end

    assign o_nonempty = (s < e);
    assign o_start    = s[FRAME_W-1:0];
    assign o_end      = e[FRAME_W-1:0];

endmodule

>>> design/memory_range_page_size_splitter_core.sv
// ----------------------------------------------------------------------------
// memory_range_page_size_splitter_core
// Splits a physical byte range into 4K / 2M / 1G mapped pieces.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one byte range
//   [start, end). Output channel (o_out_valid / i_out_stall / o_out_data)
//   carries the merged pieces in ascending order, the final one flagged by
//   piece_last. An empty or reversed range produces no transfer.
//   The large page enable mask is written over the APB port at address 0.
//   Walk: after a range is taken, five sequencer steps run one candidate
//   piece each through the shared align and clamp unit, then one flush step
//   sends the final piece; the next range is taken only after the flush.
//   o_in_stall is high for the whole walk. The first piece enters the output
//   register when a later step finds a piece that does not merge, or at flush.
//   A stalled receiver holds the output register; the sequencer holds a step
//   with a piece to send until that register frees up, so no piece is lost.
//   Reset clears the mask, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module memory_range_page_size_splitter_core #(
    parameter int PHYS_ADDR_BITS = mrps_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mrps_pkg::t_range_in          i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mrps_pkg::t_piece_out         o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrps_pkg::PADDR_W-1:0] paddr,
    input  logic [mrps_pkg::PDATA_W-1:0] pwdata,
    output logic [mrps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import mrps_pkg::*;

    localparam int PA_W    = (PHYS_ADDR_BITS < ADDR_W) ? PHYS_ADDR_BITS : ADDR_W;
    localparam int FRAME_W = PA_W - FRAME_SHIFT;

    t_state               r_state;
    t_state               n_state;
    t_seq_ctl             ctl;
    t_seg_sel             seg_sel;

    logic [LPE_W-1:0]     lpe;
    logic [FRAME_W-1:0]   r_pos;
    logic [FRAME_W-1:0]   r_limit;
    logic                 r_pend_valid;
    logic [FRAME_W-1:0]   r_pend_start;
    logic [FRAME_W-1:0]   r_pend_end;
    logic [1:0]           r_pend_tag;
    logic                 r_out_valid;
    t_piece_out           r_out_data;

    logic [FRAME_W-1:0]   seg_start;
    logic [FRAME_W-1:0]   seg_end;
    logic [1:0]           seg_tag;
    logic                 seg_nonempty;

    logic                 in_xfer;
    logic                 out_free;
    logic                 merge;
    logic                 need_emit;
    logic                 seg_state;

    mrps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_lpe   (lpe)
    );

    mrps_seg_unit #(
        .FRAME_W (FRAME_W)
    ) u_seg (
        .i_sel      (seg_sel),
        .i_pos      (r_pos),
        .i_limit    (r_limit),
        .i_lpe      (lpe),
        .o_start    (seg_start),
        .o_end      (seg_end),
        .o_tag      (seg_tag),
        .o_nonempty (seg_nonempty)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign merge       = r_pend_valid && (r_pend_tag == seg_tag) && (r_pend_end == seg_start);
    assign need_emit   = seg_nonempty && r_pend_valid && !merge;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        unique case (r_state)
            ST_HEAD:   seg_sel = SEG_HEAD_4K;
            ST_RUN2M:  seg_sel = SEG_RUN_2M;
            ST_MID1G:  seg_sel = SEG_MID_1G;
            ST_TAIL2M: seg_sel = SEG_TAIL_2M;
            ST_TAIL4K: seg_sel = SEG_TAIL_4K;
            default:   seg_sel = SEG_HEAD_4K;
        endcase
    end

    assign seg_state = (r_state == ST_HEAD) || (r_state == ST_RUN2M) ||
                       (r_state == ST_MID1G) || (r_state == ST_TAIL2M) ||
                       (r_state == ST_TAIL4K);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_xfer) n_state = ST_HEAD;
            ST_HEAD:   if (!need_emit || out_free) n_state = ST_RUN2M;
            ST_RUN2M:  if (!need_emit || out_free) n_state = ST_MID1G;
            ST_MID1G:  if (!need_emit || out_free) n_state = ST_TAIL2M;
            ST_TAIL2M: if (!need_emit || out_free) n_state = ST_TAIL4K;
            ST_TAIL4K: if (!need_emit || out_free) n_state = ST_FLUSH;
            ST_FLUSH:  if (!r_pend_valid || out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl = '0;
        if (seg_state && (!need_emit || out_free)) begin
            ctl.emit        = need_emit;
            ctl.pend_load   = seg_nonempty && !merge;
            ctl.pend_extend = seg_nonempty && merge;
            ctl.pos_load    = seg_nonempty;
        end else if ((r_state == ST_FLUSH) && r_pend_valid && out_free) begin
            ctl.emit       = 1'b1;
            ctl.last       = 1'b1;
            ctl.pend_clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pos   <= i_in_data.range_start_addr[PA_W-1:FRAME_SHIFT];
            r_limit <= i_in_data.range_end_addr[PA_W-1:FRAME_SHIFT];
        end else if (ctl.pos_load) begin
            r_pos <= seg_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (ctl.pend_clear) begin
            r_pend_valid <= 1'b0;
        end else if (ctl.pend_load) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pend_load) begin
            r_pend_start <= seg_start;
            r_pend_end   <= seg_end;
            r_pend_tag   <= seg_tag;
        end else if (ctl.pend_extend) begin
            r_pend_end <= seg_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_out_data.piece_start_addr <= ADDR_W'(r_pend_start) << FRAME_SHIFT;
            r_out_data.piece_end_addr   <= ADDR_W'(r_pend_end) << FRAME_SHIFT;
            r_out_data.piece_page_size  <= r_pend_tag;
            r_out_data.piece_last       <= ctl.last;
        end
    end

`ifndef ASSERT_OFF
    a_piece_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.piece_start_addr < o_out_data.piece_end_addr))
        else $error("emitted piece is empty");

    a_piece_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.piece_start_addr[FRAME_SHIFT-1:0] == '0) &&
                         (o_out_data.piece_end_addr[FRAME_SHIFT-1:0] == '0)))
        else $error("emitted piece not frame aligned");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> ((r_pend_start < r_pend_end) && (r_pend_end <= r_limit)))
        else $error("pending piece outside the range");

    a_walk_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_HEAD) && !r_pend_valid)
        else $error("walk did not start cleanly after input transfer");
`endif

endmodule
